[hdl/bbr_pkg.sv]
`default_nettype none

package bbr_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;

  // Frame limits and register reset values.
  localparam int HEIGHT_LIMIT = 4096;
  localparam int FW_RESET     = 1024;
  localparam int FH_RESET     = 768;

  // Queue sizes between and behind the two halves.
  localparam int JQ_DEPTH = 4;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One line store entry: the row before last and the last row at one column.
  typedef struct packed {
    rgb_t row1;
    rgb_t row0;
  } line_t;

  // Column sums (up to three pixels) and window sums (up to nine), red at [2].
  typedef logic [2:0][9:0]  csum_t;
  typedef logic [2:0][11:0] sum_t;

  // Which window columns and how many rows make up each result of one item.
  typedef struct packed {
    logic       any;
    logic       two;
    logic [2:0] m0;
    logic [2:0] m1;
    logic [1:0] rows;
    logic       fe;
  } res_ctl_t;

  // One or two results waiting for the divide.
  typedef struct packed {
    logic       two;
    logic       fe;
    sum_t       sum0;
    logic [3:0] n0;
    sum_t       sum1;
    logic [3:0] n1;
  } job_t;

  function automatic csum_t sum3(rgb_t p0, rgb_t p1, rgb_t p2);
    csum_t s;
    s[2] = 10'(p0.red) + 10'(p1.red) + 10'(p2.red);
    s[1] = 10'(p0.green) + 10'(p1.green) + 10'(p2.green);
    s[0] = 10'(p0.blue) + 10'(p1.blue) + 10'(p2.blue);
    return s;
  endfunction

  function automatic sum_t win_sum(logic [2:0] m, csum_t c0, csum_t c1, csum_t c2);
    sum_t s;
    for (int k = 0; k < 3; k++) begin
      s[k] = (m[0] ? 12'(c0[k]) : 12'd0) + (m[1] ? 12'(c1[k]) : 12'd0)
           + (m[2] ? 12'(c2[k]) : 12'd0);
    end
    return s;
  endfunction

  function automatic logic [3:0] win_count(logic [2:0] m, logic [1:0] rows);
    logic [3:0] cols;
    cols = 4'(m[0]) + 4'(m[1]) + 4'(m[2]);
    return 4'(cols * {2'b00, rows});
  endfunction

  // Reciprocal for dividing by twice the count: q = (x * mul) >> (16 + sh).
  function automatic logic [16:0] div_mul(logic [3:0] n);
    logic [16:0] m;
    case (n)
      4'd3, 4'd6: m = 17'd21846;
      4'd9:       m = 17'd7282;
      default:    m = 17'd65536;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] div_sh(logic [3:0] n);
    logic [1:0] s;
    case (n)
      4'd2, 4'd6: s = 2'd2;
      4'd4:       s = 2'd3;
      default:    s = 2'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/bbr_front.sv]
`default_nettype none

module bbr_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bbr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              push_i,
  input  wire bbr_pkg::pix_in_t                  in_data_i,
  input  wire logic [bbr_pkg::JQ_CNT_W-1:0]      jq_count_i,
  output logic                                   full_o,
  output logic                                   job_valid_o,
  output bbr_pkg::job_t                          job_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef struct packed {
    logic          drain;
    logic [AW-1:0] idx;
    logic          c_ge1;
    logic          c_ge2;
    logic          last;
    logic          r_ge1;
    logic          r_ge2;
    logic          h_ge2;
    bbr_pkg::rgb_t px;
  } s1_t;

  logic [bbr_pkg::FW_W-1:0]  fw_q;
  logic [bbr_pkg::FH_W-1:0]  fh_q;
  logic [AW-1:0]             col_q, col_d;
  logic [bbr_pkg::ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]             didx_q, didx_d;
  logic                      pend_q, pend_d;

  logic [13:0]               weff;
  logic [12:0]               heff;
  logic [AW-1:0]             wlast;
  logic [bbr_pkg::ROW_W-1:0] hlast;

  logic                      accept, is_drain, take_px, take_dr, cfg_hit;
  logic [3:0]                credit;

  logic                      r1_v_q;
  s1_t                       r1_q, r1_d;
  bbr_pkg::res_ctl_t         r2_q, r2_d;

  bbr_pkg::line_t            mem [MAX_WIDTH];
  bbr_pkg::line_t            rd_a_q, rd_b_q, fwd_data_q, data_a, data_b, wr_data;
  logic                      fwd_a_q, fwd_b_q, mem_we;
  logic [AW-1:0]             addr_a, addr_b;

  bbr_pkg::csum_t            col0_q, col1_q, col2_q;
  bbr_pkg::csum_t            cs_new, cs_a, cs_b;
  logic                      va, vb;
  logic [2:0]                ma, mb;

  // Effective frame size, saturated into the legal range.
  always_comb begin
    weff = 14'(fw_q);
    if (weff == 14'd0) begin
      weff = 14'd1;
    end else if (weff > 14'(MAX_WIDTH)) begin
      weff = 14'(MAX_WIDTH);
    end
    heff = fh_q;
    if (heff == 13'd0) begin
      heff = 13'd1;
    end else if (heff > 13'(bbr_pkg::HEIGHT_LIMIT)) begin
      heff = 13'(bbr_pkg::HEIGHT_LIMIT);
    end
  end

  assign wlast = AW'(weff - 14'd1);
  assign hlast = bbr_pkg::ROW_W'(heff - 13'd1);

  // Credit: every beat in flight has a job queue slot reserved for it.
  assign credit   = 4'(jq_count_i) + 4'(r1_v_q) + 4'(r2_q.any);
  assign full_o   = (credit >= 4'(bbr_pkg::JQ_DEPTH));
  assign accept   = push_i && !full_o;
  assign is_drain = (in_data_i.opcode == bbr_pkg::OP_DRAIN);
  assign take_px  = accept && !is_drain && !pend_q;
  assign take_dr  = accept && is_drain && pend_q;

  // Register decode.
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbr_pkg::REG_FRAME_WIDTH:  cfg_hit = 1'b1;
        bbr_pkg::REG_FRAME_HEIGHT: cfg_hit = 1'b1;
        default:                   cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= bbr_pkg::FW_W'(bbr_pkg::FW_RESET);
      fh_q <= bbr_pkg::FH_W'(bbr_pkg::FH_RESET);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bbr_pkg::REG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[bbr_pkg::FW_W-1:0];
      end
      if (cfg_idx_i == bbr_pkg::REG_FRAME_HEIGHT) begin
        fh_q <= cfg_data_i;
      end
    end
  end

  // Raster position and drain sequencing.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    didx_d = didx_q;
    pend_d = pend_q;
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      didx_d = '0;
      pend_d = 1'b0;
    end else if (take_px) begin
      if (col_q == wlast) begin
        col_d = '0;
        if (row_q == hlast) begin
          row_d  = '0;
          pend_d = 1'b1;
          didx_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (take_dr) begin
      if (didx_q == wlast) begin
        pend_d = 1'b0;
        didx_d = '0;
      end else begin
        didx_d = didx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      didx_q <= '0;
      pend_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      didx_q <= didx_d;
      pend_q <= pend_d;
    end
  end

  // Classify the accepted beat into first stage flags.
  always_comb begin
    r1_d.drain = take_dr;
    r1_d.idx   = take_dr ? didx_q : col_q;
    r1_d.c_ge1 = take_dr ? (didx_q != '0) : (col_q != '0);
    r1_d.c_ge2 = (col_q > AW'(1));
    r1_d.last  = take_dr ? (didx_q == wlast) : (col_q == wlast);
    r1_d.r_ge1 = (row_q != '0);
    r1_d.r_ge2 = (row_q > bbr_pkg::ROW_W'(1));
    r1_d.h_ge2 = (hlast != '0);
    r1_d.px    = '{red: in_data_i.red_in, green: in_data_i.green_in,
                   blue: in_data_i.blue_in};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else begin
      r1_v_q <= take_px || take_dr;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= r1_d;
  end

  // Line store: pixels read and write one column; drains read two columns.
  assign addr_a  = take_dr ? didx_q : col_q;
  assign addr_b  = (didx_q == wlast) ? didx_q : didx_q + 1'b1;
  assign data_a  = fwd_a_q ? fwd_data_q : rd_a_q;
  assign data_b  = fwd_b_q ? fwd_data_q : rd_b_q;
  assign mem_we  = r1_v_q && !r1_q.drain;
  assign wr_data = '{row1: data_a.row0, row0: r1_q.px};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[r1_q.idx] <= wr_data;
    end
    rd_a_q     <= mem[addr_a];
    rd_b_q     <= mem[addr_b];
    fwd_data_q <= wr_data;
  end

  // A write and a read of the same column in one cycle take the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= mem_we && (r1_q.idx == addr_a);
      fwd_b_q <= mem_we && (r1_q.idx == addr_b);
    end
  end

  // Column sums, with rows outside the frame left out.
  assign cs_new = bbr_pkg::sum3(r1_q.r_ge2 ? data_a.row1 : '0, data_a.row0, r1_q.px);
  assign cs_a   = bbr_pkg::sum3(r1_q.h_ge2 ? data_a.row1 : '0, data_a.row0, '0);
  assign cs_b   = bbr_pkg::sum3(r1_q.h_ge2 ? data_b.row1 : '0, data_b.row0, '0);

  always_ff @(posedge clk_i) begin
    if (r1_v_q) begin
      col0_q <= col1_q;
      col1_q <= r1_q.drain ? cs_a : col2_q;
      col2_q <= r1_q.drain ? cs_b : cs_new;
    end
  end

  // Result selection: which columns of the window and how many rows.
  always_comb begin
    if (r1_q.drain) begin
      va = 1'b1;
      ma = {!r1_q.last, 1'b1, r1_q.c_ge1};
      vb = 1'b0;
      mb = '0;
    end else begin
      va = r1_q.r_ge1 && r1_q.c_ge1;
      ma = {1'b1, 1'b1, r1_q.c_ge2};
      vb = r1_q.r_ge1 && r1_q.last;
      mb = {1'b1, r1_q.c_ge1, 1'b0};
    end
    r2_d.any  = r1_v_q && (va || vb);
    r2_d.two  = va && vb;
    r2_d.m0   = va ? ma : mb;
    r2_d.m1   = mb;
    r2_d.rows = r1_q.drain ? (r1_q.h_ge2 ? 2'd2 : 2'd1) : (r1_q.r_ge2 ? 2'd3 : 2'd2);
    r2_d.fe   = r1_q.drain && r1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else begin
      r2_q <= r2_d;
    end
  end

  // Window sums for the job queue.
  assign job_valid_o = r2_q.any;
  assign job_o.two   = r2_q.two;
  assign job_o.fe    = r2_q.fe;
  assign job_o.sum0  = bbr_pkg::win_sum(r2_q.m0, col0_q, col1_q, col2_q);
  assign job_o.n0    = bbr_pkg::win_count(r2_q.m0, r2_q.rows);
  assign job_o.sum1  = bbr_pkg::win_sum(r2_q.m1, col0_q, col1_q, col2_q);
  assign job_o.n1    = bbr_pkg::win_count(r2_q.m1, r2_q.rows);

endmodule

`default_nettype wire

[hdl/bbr_jobq.sv]
`default_nettype none

module bbr_jobq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire bbr_pkg::job_t                 job_i,
  input  wire logic                          pop_i,
  output bbr_pkg::job_t                      job_o,
  output logic                               empty_o,
  output logic [bbr_pkg::JQ_CNT_W-1:0]       count_o
);

  bbr_pkg::job_t                 mem_q [bbr_pkg::JQ_DEPTH];
  logic [bbr_pkg::JQ_PTR_W-1:0]  wptr_q, rptr_q;
  logic [bbr_pkg::JQ_CNT_W-1:0]  cnt_q;

  assign job_o   = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  // Storage; the front never pushes without a reserved slot.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + bbr_pkg::JQ_CNT_W'(push_i) - bbr_pkg::JQ_CNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

[hdl/bbr_back.sv]
`default_nettype none

module bbr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bbr_pkg::job_t job_i,
  input  wire logic          jq_empty_i,
  output logic               jq_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output bbr_pkg::pix_out_t  out_data_o
);

  logic                          issue, sel_q;
  logic [bbr_pkg::OQ_CNT_W:0]    ocredit;
  bbr_pkg::sum_t                 s;
  logic [3:0]                    n;

  logic                          b1_v_q, b2_v_q;
  logic [2:0][12:0]              b1_x_q;
  logic [16:0]                   b1_mul_q;
  logic [1:0]                    b1_sh_q, b2_sh_q;
  logic                          b1_fe_q, b2_fe_q;
  logic [2:0][29:0]              b2_prod_q;
  logic [2:0][7:0]               q;

  bbr_pkg::pix_out_t             ofifo_q [bbr_pkg::OQ_DEPTH];
  logic [bbr_pkg::OQ_PTR_W-1:0]  owptr_q, orptr_q;
  logic [bbr_pkg::OQ_CNT_W-1:0]  ocnt_q;
  logic                          opop;

  // Issue one result a cycle while a job waits and the output queue has room for it.
  assign ocredit  = (bbr_pkg::OQ_CNT_W+1)'(ocnt_q) + (bbr_pkg::OQ_CNT_W+1)'(b1_v_q)
                  + (bbr_pkg::OQ_CNT_W+1)'(b2_v_q);
  assign issue    = !jq_empty_i && (ocredit < (bbr_pkg::OQ_CNT_W+1)'(bbr_pkg::OQ_DEPTH));
  assign jq_pop_o = issue && (sel_q || !job_i.two);
  assign s        = sel_q ? job_i.sum1 : job_i.sum0;
  assign n        = sel_q ? job_i.n1 : job_i.n0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= 1'b0;
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      if (issue) begin
        sel_q <= !sel_q && job_i.two;
      end
      b1_v_q <= issue;
      b2_v_q <= b1_v_q;
    end
  end

  // Rounded mean: (2*sum + n) / (2*n) through a reciprocal multiply.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      b1_x_q[k]    <= {s[k], 1'b0} + 13'(n);
      b2_prod_q[k] <= 30'(b1_x_q[k]) * 30'(b1_mul_q);
    end
    b1_mul_q <= bbr_pkg::div_mul(n);
    b1_sh_q  <= bbr_pkg::div_sh(n);
    b1_fe_q  <= !sel_q && job_i.fe;
    b2_sh_q  <= b1_sh_q;
    b2_fe_q  <= b1_fe_q;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (b2_sh_q)
        2'd2:    q[k] = b2_prod_q[k][25:18];
        2'd3:    q[k] = b2_prod_q[k][26:19];
        default: q[k] = b2_prod_q[k][24:17];
      endcase
    end
  end

  // Output queue; its head drives the result ports.
  assign opop       = pop_i && !empty_o;
  assign empty_o    = (ocnt_q == '0);
  assign out_data_o = ofifo_q[orptr_q];

  always_ff @(posedge clk_i) begin
    if (b2_v_q) begin
      ofifo_q[owptr_q] <= '{red_out: q[2], green_out: q[1], blue_out: q[0],
                            frame_end: b2_fe_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (b2_v_q) begin
        owptr_q <= owptr_q + 1'b1;
      end
      if (opop) begin
        orptr_q <= orptr_q + 1'b1;
      end
      ocnt_q <= ocnt_q + bbr_pkg::OQ_CNT_W'(b2_v_q) - bbr_pkg::OQ_CNT_W'(opop);
    end
  end

endmodule

`default_nettype wire

[hdl/box_blur_3x3_rgb.sv]
// Channel  | Direction | Handshake                | Beat
// ---------+-----------+--------------------------+-----------------------------------
// input    | in        | push_i / full_o          | in_data_i: opcode, red, green, blue
// result   | out       | empty_o / pop_i          | out_data_o: red, green, blue, end
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One input beat is taken every cycle while full_o is low; a row-end pixel after the
// first row yields up to two results, which leave one a cycle through the single result
// port while pop_i is high. A result passes the front stages (line store read, column
// sums, window sums), the job queue and two divide stages before the output queue.
// Reset is asynchronous; the line store is not cleared and needs no pass after reset.
// full_o rises when the four-entry job queue has no slot left for beats in flight;
// a stalled pop_i fills the output queue first, then the job queue.
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire bbr_pkg::pix_in_t               in_data_i,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output bbr_pkg::pix_out_t                   out_data_o
);

  logic                          job_valid, jq_empty, jq_pop;
  bbr_pkg::job_t                 job_in, job_head;
  logic [bbr_pkg::JQ_CNT_W-1:0]  jq_count;

  // Front: position tracking, line store and window.
  bbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .in_data_i   (in_data_i),
    .jq_count_i  (jq_count),
    .full_o      (full_o),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // Queue between the window sums and the divide.
  bbr_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job_in),
    .pop_i   (jq_pop),
    .job_o   (job_head),
    .empty_o (jq_empty),
    .count_o (jq_count)
  );

  // Back: rounding divide and output queue.
  bbr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_head),
    .jq_empty_i (jq_empty),
    .jq_pop_o   (jq_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/bbr_checker.sv]
`default_nettype none

module bbr_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push_i,
  input wire logic              full_o,
  input wire logic              empty_o,
  input wire logic              pop_i,
  input wire bbr_pkg::pix_out_t out_data_o
);

  // Coming out of reset nothing is queued and input is open.
  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (empty_o && !full_o))
    else $error("block not empty or full right after reset");

  // Backpressure can only grow after an input beat was taken.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i && !full_o))
    else $error("full_o rose without an accepted input beat");

  // A waiting result stays until popped.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("result withdrawn before pop");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> $stable(out_data_o))
    else $error("result changed while waiting");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;

  localparam int LINE_MAX = 1024;

  // Predicts the blurred pixel stream and holds the pixels still owed by the block.
  class blur_scoreboard;
    bit [23:0]         line_mem[2][LINE_MAX];
    bit [23:0]         win[3][3];
    int                col_pos;
    int                row_pos;
    int                flush_col;
    bit                flush_armed;
    int                width_reg;
    int                height_reg;
    bbr_pkg::pix_out_t owed_q[$];
    int                errors;
    int                pixels_seen;
    int                results_seen;

    function void reset_state();
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      flush_col = 0;
      flush_armed = 0;
      width_reg = bbr_pkg::FW_RESET;
      height_reg = bbr_pkg::FH_RESET;
    endfunction

    function int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > bbr_pkg::HEIGHT_LIMIT) return bbr_pkg::HEIGHT_LIMIT;
      return height_reg;
    endfunction

    // A write to either register restarts the frame; other indexes do nothing.
    function void write_reg(bbr_pkg::cfg_reg_e idx, int data);
      if (idx == bbr_pkg::REG_FRAME_WIDTH) width_reg = data & 'h7ff;
      else if (idx == bbr_pkg::REG_FRAME_HEIGHT) height_reg = data & 'h1fff;
      else return;
      col_pos = 0;
      row_pos = 0;
      flush_col = 0;
      flush_armed = 0;
    endfunction

    // Rounds to nearest with halves up, per color.
    function bbr_pkg::pix_out_t rounded_mean(int sr, int sg, int sb, int cnt, bit fe);
      bbr_pkg::pix_out_t p;
      p.red_out   = 8'((2 * sr + cnt) / (2 * cnt));
      p.green_out = 8'((2 * sg + cnt) / (2 * cnt));
      p.blue_out  = 8'((2 * sb + cnt) / (2 * cnt));
      p.frame_end = fe;
      return p;
    endfunction

    function bbr_pkg::pix_out_t window_mean(int first_row, int first_col);
      int sr, sg, sb, cnt;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      for (int i = first_row; i < 3; i++) begin
        for (int j = first_col; j < 3; j++) begin
          sr += win[i][j][23:16];
          sg += win[i][j][15:8];
          sb += win[i][j][7:0];
          cnt++;
        end
      end
      return rounded_mean(sr, sg, sb, cnt, 1'b0);
    endfunction

    // Returns 1 when the beat does work, 0 when the block ignores it.
    function bit note_input(bbr_pkg::pix_in_t it);
      int w, h, c, r, d, lo, hi, sr, sg, sb, cnt, first_row;
      bit [23:0] a, b;
      w = eff_width();
      h = eff_height();
      if (it.opcode == bbr_pkg::OP_DRAIN) begin
        if (!flush_armed) return 0;
        d = flush_col % LINE_MAX;
        lo = (d == 0) ? 0 : d - 1;
        hi = (d + 1 < w) ? d + 1 : d;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int x = lo; x <= hi; x++) begin
          for (int k = 0; k < 2; k++) begin
            if (k == 0 || h >= 2) begin
              sr += line_mem[k][x][23:16];
              sg += line_mem[k][x][15:8];
              sb += line_mem[k][x][7:0];
              cnt++;
            end
          end
        end
        owed_q.push_back(rounded_mean(sr, sg, sb, cnt, d + 1 >= w));
        if (d + 1 >= w) begin
          flush_armed = 0;
          flush_col = 0;
        end else begin
          flush_col = d + 1;
        end
        return 1;
      end
      if (flush_armed) return 0;
      pixels_seen++;
      c = col_pos % LINE_MAX;
      r = row_pos;
      a = line_mem[0][c];
      b = line_mem[1][c];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = b;
      win[1][2] = a;
      win[2][2] = {it.red_in, it.green_in, it.blue_in};
      line_mem[1][c] = a;
      line_mem[0][c] = win[2][2];
      first_row = (r >= 2) ? 0 : 1;
      if (r >= 1 && c >= 1) owed_q.push_back(window_mean(first_row, (c >= 2) ? 0 : 1));
      if (r >= 1 && c + 1 >= w) owed_q.push_back(window_mean(first_row, (c >= 1) ? 1 : 2));
      if (c + 1 >= w) begin
        col_pos = 0;
        if (r + 1 >= h) begin
          row_pos = 0;
          flush_armed = 1;
          flush_col = 0;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
      return 1;
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("ERROR at %0t: result %0d %s got %0d expected %0d",
               $time, results_seen, what, got, want);
      errors++;
    endtask

    task check_result(bbr_pkg::pix_out_t got);
      bbr_pkg::pix_out_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected beat, frame_end", got.frame_end, -1);
        return;
      end
      want = owed_q.pop_front();
      if (got.red_out != want.red_out) report_mismatch("red", got.red_out, want.red_out);
      if (got.green_out != want.green_out)
        report_mismatch("green", got.green_out, want.green_out);
      if (got.blue_out != want.blue_out) report_mismatch("blue", got.blue_out, want.blue_out);
      if (got.frame_end != want.frame_end)
        report_mismatch("frame_end", got.frame_end, want.frame_end);
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           push_i;
  logic                           full_o;
  bbr_pkg::pix_in_t               in_data_i;
  logic                           empty_o;
  logic                           pop_i;
  bbr_pkg::pix_out_t              out_data_o;

  blur_scoreboard sb;
  bit             send_fast;
  bit             pop_fast;
  int             work_items;
  int             frames_done;

  box_blur_3x3_rgb u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_data_i  (in_data_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Safety net against a hung handshake.
  initial begin
    #40000000;
    $display("Timeout waiting on the block");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sends one beat after a random gap; leaves push high for a back-to-back beat.
  task send_beat(bit op, bit [7:0] r, bit [7:0] g, bit [7:0] b);
    int gap;
    bbr_pkg::pix_in_t it;
    gap = send_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.opcode = op;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    push_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    if (sb.note_input(it)) work_items++;
    @(negedge clk_i);
  endtask

  task send_pixel();
    send_beat(bbr_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task send_drain();
    send_beat(bbr_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until every owed pixel has come out, plus the pipeline depth.
  task wait_quiet();
    push_i <= 1'b0;
    while (sb.owed_q.size() > 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task write_reg(bbr_pkg::cfg_reg_e idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= bbr_pkg::CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // One full frame of random pixels, optionally with ignored beats mixed in.
  task run_frame(bit noisy);
    int w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noisy && $urandom_range(0, 19) == 0) send_drain();
        send_pixel();
      end
    end
    if (noisy && $urandom_range(0, 3) == 0) send_pixel();
    for (int c = 0; c < w; c++) send_drain();
    if (noisy && $urandom_range(0, 3) == 0) send_drain();
    frames_done++;
  endtask

  // Result side: random stalls, sometimes long stretches of none.
  initial begin
    int stall;
    pop_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 49) == 0) pop_fast = !pop_fast;
      stall = pop_fast ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        pop_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
      sb.check_result(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int settle;
    sb = new();
    sb.reset_state();
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    push_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: 3x3 frame of extreme values with stray beats around it.
    write_reg(bbr_pkg::REG_FRAME_WIDTH, 3);
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 3);
    send_drain();
    for (int k = 0; k < 9; k++) begin
      case (k % 3)
        0: send_beat(bbr_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
        1: send_beat(bbr_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        default: send_beat(bbr_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h01);
      endcase
    end
    send_pixel();
    for (int k = 0; k < 3; k++) send_drain();
    send_drain();
    wait_quiet();

    // Directed: zero sizes saturate to one pixel; unused indexes do nothing.
    write_reg(bbr_pkg::REG_FRAME_WIDTH, 'h1800);
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 0);
    write_reg(bbr_pkg::cfg_reg_e'(2), 'h1fff);
    write_reg(bbr_pkg::cfg_reg_e'(3), 5);
    send_beat(bbr_pkg::OP_PIXEL, 8'hff, 8'h7f, 8'h80);
    send_drain();
    wait_quiet();

    // Directed: single column and single row frames.
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 3);
    run_frame(1'b0);
    wait_quiet();
    write_reg(bbr_pkg::REG_FRAME_WIDTH, 4);
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 1);
    run_frame(1'b0);
    wait_quiet();

    // Random phases of small frames.
    while (work_items < 1000) begin
      send_fast = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) write_reg(bbr_pkg::REG_FRAME_WIDTH, $urandom_range(1, 8));
      else write_reg(bbr_pkg::REG_FRAME_WIDTH, $urandom_range(9, 40));
      write_reg(bbr_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 6));
      repeat ($urandom_range(1, 2)) run_frame(1'b1);
      wait_quiet();
    end

    // Widest row through saturation on a partial frame, then the tallest height.
    send_fast = 1'b0;
    write_reg(bbr_pkg::REG_FRAME_WIDTH, 'h7ff);
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 2);
    repeat (40) send_pixel();
    wait_quiet();
    write_reg(bbr_pkg::REG_FRAME_WIDTH, 2);
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, 'h1fff);
    repeat (12) send_pixel();
    wait_quiet();
    write_reg(bbr_pkg::REG_FRAME_HEIGHT, bbr_pkg::HEIGHT_LIMIT);
    repeat (8) send_pixel();
    push_i <= 1'b0;

    settle = 0;
    while (sb.owed_q.size() > 0 && settle < 5000) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (20) @(negedge clk_i);
    if (sb.owed_q.size() > 0)
      sb.report_mismatch("pixels never delivered, count", 0, sb.owed_q.size());

    $display("Covered %0d working beats (%0d pixels) over %0d frames, %0d results checked.",
             work_items, sb.pixels_seen, frames_done, sb.results_seen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/bbr_pkg.sv
hdl/bbr_front.sv
hdl/bbr_jobq.sv
hdl/bbr_back.sv
hdl/box_blur_3x3_rgb.sv
hdl/bbr_checker.sv
sim/testbench.sv
